### rtl/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types and constants for the subset-sum window check.
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int AMOUNT_W        = 24;   // width of one amount
  localparam int CFG_W           = 12;   // width of target_sum and tolerance
  localparam int CFG_IDX_W       = 4;    // width of the register index
  localparam int UPPER_W         = 13;   // target_sum + tolerance
  localparam int WORD_W          = 64;   // bits per word of the sum set
  localparam int SHIFT_W         = 6;    // log2 of WORD_W
  localparam int MAX_SUM_DEFAULT = 4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SUM = 4'd0,
    CFG_TOLERANCE  = 4'd1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // latch a new amount and start a pass
    logic load_wipe;    // start a pass that only clears the set
    logic issue;        // issue one word of the pass
    logic result_load;  // move the result into the output register
  } ssw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;   // last slot of the pass is being issued
    logic report;       // current pass ends in a result
  } ssw_status_t;

endpackage

### rtl/ssw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_in_if
// Request channel carrying one amount and its end-of-set mark.
// ----------------------------------------------------------------------------
interface ssw_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssw_pkg::AMOUNT_W-1:0]  amount;
  logic                          last;

  modport source (output valid, output amount, output last, input ready);
  modport sink   (input valid, input amount, input last, output ready);
endinterface

### rtl/ssw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_out_if
// Result channel carrying the window check outcome.
// ----------------------------------------------------------------------------
interface ssw_out_if;
  logic valid;
  logic ready;
  logic found;
  logic out_of_range;

  modport source (output valid, output found, output out_of_range, input ready);
  modport sink   (input valid, input found, input out_of_range, output ready);
endinterface

### rtl/ssw_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface ssw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssw_pkg::CFG_IDX_W-1:0]  index;
  logic [ssw_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/subset_sum_window_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_window_check
// Keeps the set of reachable subset sums of a run of amounts and reports
// whether a nonzero sum falls in the target window on the last amount.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                 Accepted when
//   -------  ---  ----------------------  -------------------------
//   item     in   amount[23:0], last      item.valid & item.ready
//   result   out  found, out_of_range     result.valid & result.ready
//   cfg      in   index[3:0], data[11:0]  cfg.valid & cfg.ready
//
// A request is accepted in the idle state; the sweep state then issues every
// word of the RAM, top word first, plus one closing slot, and the pass ends in
// the drain state. A request marked last also passes the result state.
// After reset a clearing pass over every word runs before the first request;
// register writes are taken at any time. The next request is accepted while a
// result waits; a second result holds until the first one is taken.
//
module subset_sum_window_check #(
  parameter int MAX_SUM = ssw_pkg::MAX_SUM_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  ssw_in_if.sink     item,
  ssw_out_if.source  result,
  ssw_cfg_if.sink    cfg
);

  localparam int WORDS  = MAX_SUM / ssw_pkg::WORD_W + 1;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Configuration registers: always ready, unknown indexes are dropped.
  logic [ssw_pkg::CFG_W-1:0] target_sum;
  logic [ssw_pkg::CFG_W-1:0] tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
      tolerance  <= '0;
    end else if (cfg.valid) begin
      case (ssw_pkg::cfg_reg_t'(cfg.index))
        ssw_pkg::CFG_TARGET_SUM: target_sum <= cfg.data;
        ssw_pkg::CFG_TOLERANCE:  tolerance  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Controller and datapath talk through the command and status structs only.
  ssw_pkg::ssw_cmd_t    cmd;
  ssw_pkg::ssw_status_t status;

  ssw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Sum set storage: one word of 64 sums per entry.
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ssw_pkg::WORD_W-1:0]  wr_data;
  logic [ADDR_W-1:0]           rd_addr_a;
  logic [ADDR_W-1:0]           rd_addr_b;
  logic [ssw_pkg::WORD_W-1:0]  rd_data_a;
  logic [ssw_pkg::WORD_W-1:0]  rd_data_b;

  ssw_datapath #(
    .MAX_SUM (MAX_SUM)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .target_sum   (target_sum),
    .tolerance    (tolerance),
    .amount       (item.amount),
    .last         (item.last),
    .found        (result.found),
    .out_of_range (result.out_of_range),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b)
  );

  // Sweep runs from the top word down, so each word is rewritten only after
  // every read that needs its old value.
  ssw_ram #(
    .WIDTH (ssw_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

endmodule

### rtl/ssw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ssw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/ssw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_ctrl
// Sequencer: clearing pass after reset, one sweep per amount, result hand-off.
// ----------------------------------------------------------------------------
module ssw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ssw_pkg::ssw_cmd_t     cmd,
  input  ssw_pkg::ssw_status_t  status
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.load_wipe = 1'b1;
        state_next    = ST_SWEEP;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (status.issue_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write of the pass lands in this cycle
        state_next = status.report ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (!result_valid || result_ready) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/ssw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_datapath
// Word sweep over the sum set: shift-or with cap mask, window scan, clear.
// ----------------------------------------------------------------------------
module ssw_datapath #(
  parameter int MAX_SUM = ssw_pkg::MAX_SUM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssw_pkg::ssw_cmd_t                 cmd,
  output ssw_pkg::ssw_status_t              status,
  input  logic [ssw_pkg::CFG_W-1:0]         target_sum,
  input  logic [ssw_pkg::CFG_W-1:0]         tolerance,
  input  logic [ssw_pkg::AMOUNT_W-1:0]      amount,
  input  logic                              last,
  output logic                              found,
  output logic                              out_of_range,
  output logic                              wr_en,
  output logic [((MAX_SUM / ssw_pkg::WORD_W + 1 > 1) ?
                 $clog2(MAX_SUM / ssw_pkg::WORD_W + 1) : 1)-1:0] wr_addr,
  output logic [ssw_pkg::WORD_W-1:0]        wr_data,
  output logic [((MAX_SUM / ssw_pkg::WORD_W + 1 > 1) ?
                 $clog2(MAX_SUM / ssw_pkg::WORD_W + 1) : 1)-1:0] rd_addr_a,
  output logic [((MAX_SUM / ssw_pkg::WORD_W + 1 > 1) ?
                 $clog2(MAX_SUM / ssw_pkg::WORD_W + 1) : 1)-1:0] rd_addr_b,
  input  logic [ssw_pkg::WORD_W-1:0]        rd_data_a,
  input  logic [ssw_pkg::WORD_W-1:0]        rd_data_b
);

  localparam int WORDS  = MAX_SUM / ssw_pkg::WORD_W + 1;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(WORDS + 1);
  localparam int BASE_W = ADDR_W + ssw_pkg::SHIFT_W;
  localparam int CMP_W  = ((BASE_W > ssw_pkg::UPPER_W) ? BASE_W : ssw_pkg::UPPER_W) + 1;
  localparam int WS_W   = ssw_pkg::UPPER_W - ssw_pkg::SHIFT_W;
  localparam int DIFF_W = ((ADDR_W > WS_W) ? ADDR_W : WS_W) + 1;
  localparam int W      = ssw_pkg::WORD_W;
  localparam int SW     = ssw_pkg::SHIFT_W;

  // bits of the word at base that are at or below lim
  function automatic logic [W-1:0] upto_mask(logic [CMP_W-1:0] base, logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] k;
    logic [W-1:0]     m;
    k = lim - base;
    if (base > lim) begin
      m = '0;
    end else if (k >= CMP_W'(W - 1)) begin
      m = '1;
    end else begin
      m = ~({W{1'b1}} << (k[SW-1:0] + SW'(1)));
    end
    return m;
  endfunction

  // bits of the word at base that are at or above lo
  function automatic logic [W-1:0] from_mask(logic [CMP_W-1:0] base, logic [CMP_W-1:0] lo);
    logic [CMP_W-1:0] d;
    logic [W-1:0]     m;
    d = lo - base;
    if (lo <= base) begin
      m = '1;
    end else if (d >= CMP_W'(W)) begin
      m = '0;
    end else begin
      m = {W{1'b1}} << d[SW-1:0];
    end
    return m;
  endfunction

  // item registers
  logic [CMP_W-1:0]  cap;
  logic [CMP_W-1:0]  lo;
  logic              oor;
  logic              add_en;
  logic [WS_W-1:0]   ws;
  logic [SW-1:0]     bs;
  logic              clear;
  logic              report;
  logic              found_acc;

  logic [ssw_pkg::UPPER_W-1:0] upper_c;
  logic [ssw_pkg::CFG_W-1:0]   diff_c;
  logic [CMP_W-1:0]            cap_c;
  logic [CMP_W-1:0]            lo_c;
  logic                        oor_c;
  logic                        add_en_c;

  always_comb begin
    upper_c  = ssw_pkg::UPPER_W'(target_sum) + ssw_pkg::UPPER_W'(tolerance);
    oor_c    = CMP_W'(upper_c) > CMP_W'(MAX_SUM);
    cap_c    = oor_c ? CMP_W'(MAX_SUM) : CMP_W'(upper_c);
    diff_c   = target_sum - tolerance;
    if (target_sum >= tolerance && diff_c != '0) begin
      lo_c = CMP_W'(diff_c);
    end else begin
      lo_c = CMP_W'(1);
    end
    add_en_c = (amount != '0) && (amount <= ssw_pkg::AMOUNT_W'(cap_c));
  end

  // issue stage
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx_w;
  logic [ADDR_W-1:0] idx;
  logic              slot_real;
  logic [DIFF_W-1:0] src_diff;
  logic              src_ok;

  assign status.issue_done = (cnt == CNT_W'(WORDS));
  assign status.report     = report;
  assign idx_w     = CNT_W'(WORDS - 1) - cnt;
  assign idx       = idx_w[ADDR_W-1:0];
  assign slot_real = !status.issue_done;
  assign src_diff  = DIFF_W'(idx) - DIFF_W'(ws);
  assign src_ok    = !src_diff[DIFF_W-1];
  assign rd_addr_a = idx;
  assign rd_addr_b = src_diff[ADDR_W-1:0];

  // read stage and combine stage
  logic              p1_real;
  logic              p1_bok;
  logic [ADDR_W-1:0] p1_idx;
  logic [CMP_W-1:0]  p1_base;
  logic              p2_real;
  logic              p2_bok;
  logic [ADDR_W-1:0] p2_idx;
  logic [W-1:0]      p2_a;
  logic [W-1:0]      p2_b;
  logic [W-1:0]      p2_capm;
  logic [W-1:0]      p2_winm;
  logic [W-1:0]      hi_part;
  logic [W-1:0]      lo_part;
  logic [W-1:0]      merged;

  assign p1_base = CMP_W'({p1_idx, SW'(0)});
  assign hi_part = p2_bok ? (p2_b << bs) : '0;
  assign lo_part = (p1_bok && bs != '0) ? (rd_data_b >> (W - {1'b0, bs})) : '0;
  assign merged  = p2_a | ((hi_part | lo_part) & p2_capm);

  assign wr_en   = p2_real;
  assign wr_addr = p2_idx;
  assign wr_data = clear ? ((p2_idx == '0) ? W'(1) : '0) : merged;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cap    <= cap_c;
      lo     <= lo_c;
      oor    <= oor_c;
      add_en <= add_en_c;
      ws     <= amount[ssw_pkg::UPPER_W-1:SW];
      bs     <= amount[SW-1:0];
      clear  <= last;
    end else if (cmd.load_wipe) begin
      add_en <= 1'b0;
      clear  <= 1'b1;
    end
    p1_idx  <= idx;
    p2_idx  <= p1_idx;
    p2_a    <= rd_data_a;
    p2_b    <= rd_data_b;
    p2_capm <= upto_mask(p1_base, cap);
    p2_winm <= upto_mask(p1_base, cap) & from_mask(p1_base, lo);
    if (cmd.result_load) begin
      found        <= found_acc;
      out_of_range <= oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      report    <= 1'b0;
      found_acc <= 1'b0;
      p1_real   <= 1'b0;
      p1_bok    <= 1'b0;
      p2_real   <= 1'b0;
      p2_bok    <= 1'b0;
    end else begin
      if (cmd.load_item || cmd.load_wipe) begin
        cnt       <= '0;
        report    <= cmd.load_item && last;
        found_acc <= 1'b0;
      end else begin
        if (cmd.issue && slot_real) begin
          cnt <= cnt + CNT_W'(1);
        end
        if (p2_real && |(merged & p2_winm)) begin
          found_acc <= 1'b1;
        end
      end
      p1_real <= cmd.issue && slot_real;
      p1_bok  <= cmd.issue && slot_real && add_en && src_ok;
      p2_real <= p1_real;
      p2_bok  <= p1_bok;
    end
  end

endmodule

### sim/subset_sum_window_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_window_check_tb
// Self-checking bench for the subset-sum window check. Requests of amounts
// are pushed through the item channel with random gaps, and results are
// drained with random stalls. A bitset predictor of the reachable sums
// forecasts each window outcome. Register settings change between phases,
// only once the block has gone quiet.
// ----------------------------------------------------------------------------
module subset_sum_window_check_tb;

  localparam int SUM_TOP       = ssw_pkg::MAX_SUM_DEFAULT;
  localparam int ITEM_GOAL     = 1950;
  localparam int SETTLE_CYCLES = 100;   // one full sweep plus margin
  localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake at all

  typedef struct packed {
    logic found;
    logic out_of_range;
  } outcome_t;

  // Bitset predictor of reachable subset sums, plus the queue of outcomes
  // still owed by the block.
  class window_predictor;
    logic [SUM_TOP:0]          reach;
    logic [ssw_pkg::CFG_W-1:0] target;
    logic [ssw_pkg::CFG_W-1:0] tol;
    outcome_t                  owed_q[$];
    int                        errors;

    function new();
      reach  = (SUM_TOP + 1)'(1);
      target = '0;
      tol    = '0;
      errors = 0;
    endfunction

    function void set_register(logic [ssw_pkg::CFG_IDX_W-1:0] idx,
                               logic [ssw_pkg::CFG_W-1:0] data);
      case (idx)
        ssw_pkg::CFG_TARGET_SUM: target = data;
        ssw_pkg::CFG_TOLERANCE:  tol = data;
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Fold one accepted amount into the set; on the last one, work out the
    // window outcome and clear the set back to sum zero only.
    function void note_amount(logic [ssw_pkg::AMOUNT_W-1:0] amt, logic lst);
      logic [ssw_pkg::UPPER_W-1:0] upper;
      int unsigned                 cap;
      int unsigned                 lo;
      logic [SUM_TOP:0]            cap_mask;
      logic [SUM_TOP:0]            window;
      outcome_t                    want;
      upper    = {1'b0, target} + {1'b0, tol};
      cap      = (upper > SUM_TOP) ? SUM_TOP : upper;
      cap_mask = {(SUM_TOP + 1){1'b1}} >> (SUM_TOP - cap);
      if (amt != 0 && amt <= cap)
        reach = reach | ((reach << amt) & cap_mask);
      if (!lst)
        return;
      lo = (target >= tol) ? target - tol : 0;
      if (lo == 0)
        lo = 1;
      window            = cap_mask & ({(SUM_TOP + 1){1'b1}} << lo);
      want.found        = |(reach & window);
      want.out_of_range = (upper > SUM_TOP);
      owed_q            = {owed_q, want};
      reach             = (SUM_TOP + 1)'(1);
    endfunction

    task check_outcome(logic found, logic out_of_range);
      outcome_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result found=%0b oor=%0b with no request owing one",
                         found, out_of_range));
        return;
      end
      want = owed_q.pop_front();
      if (found !== want.found)
        report($sformatf("found got %0b want %0b", found, want.found));
      if (out_of_range !== want.out_of_range)
        report($sformatf("out_of_range got %0b want %0b",
                         out_of_range, want.out_of_range));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  ssw_in_if  item_ch ();
  ssw_out_if result_ch ();
  ssw_cfg_if cfg_ch ();

  subset_sum_window_check #(
    .MAX_SUM (SUM_TOP)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  window_predictor sums = new();

  int          items_sent  = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 1'b0;  // no gaps and no stalls while set
  int unsigned cur_target  = 0;
  int unsigned cur_tol     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_phase)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Cap on tracked sums under the settings last written.
  function automatic int unsigned current_cap();
    int unsigned upper;
    upper = cur_target + cur_tol;
    return (upper > SUM_TOP) ? SUM_TOP : upper;
  endfunction

  // Amounts lean towards values that fit under the cap, so that sums build
  // up; zero, the full 24-bit range and the edge of the cap are mixed in.
  function automatic logic [ssw_pkg::AMOUNT_W-1:0] pick_amount();
    int unsigned cap;
    int          r;
    cap = current_cap();
    r   = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    if (r < 16)
      return ssw_pkg::AMOUNT_W'($urandom_range(0, (1 << ssw_pkg::AMOUNT_W) - 1));
    if (r < 24)
      return ssw_pkg::AMOUNT_W'(cap + $urandom_range(0, 2) - 1 + (cap == 0));
    if (r < 60)
      return ssw_pkg::AMOUNT_W'($urandom_range(1, (cap / 3 > 1) ? cap / 3 : 1));
    return ssw_pkg::AMOUNT_W'($urandom_range(1, (cap > 1) ? cap : 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Each task is entered at a falling edge and returns at one.
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken; valid stays high across
  // back-to-back requests.
  task automatic send_amount(input logic [ssw_pkg::AMOUNT_W-1:0] amt, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.amount = amt;
    item_ch.last   = lst;
    item_ch.valid  = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold the sender until every owed result has been taken.
  task automatic drain_outcomes();
    item_ch.valid = 1'b0;
    while (sums.owed_q.size() != 0)
      @(negedge clk);
  endtask

  // Drain, then let a full sweep pass in case a request with no result is
  // still working through the set.
  task automatic go_quiet();
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input ssw_pkg::cfg_reg_t idx,
                           input logic [ssw_pkg::CFG_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == ssw_pkg::CFG_TARGET_SUM)
      cur_target = 32'(data);
    else
      cur_tol = 32'(data);
  endtask

  task automatic set_window(input logic [ssw_pkg::CFG_W-1:0] tgt,
                            input logic [ssw_pkg::CFG_W-1:0] tl);
    go_quiet();
    if ($urandom_range(0, 1)) begin
      write_reg(ssw_pkg::CFG_TARGET_SUM, tgt);
      write_reg(ssw_pkg::CFG_TOLERANCE, tl);
    end else begin
      write_reg(ssw_pkg::CFG_TOLERANCE, tl);
      write_reg(ssw_pkg::CFG_TARGET_SUM, tgt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge and feed the predictor.
  // Check the result before noting a request taken on the same edge, since a
  // result can never belong to a request accepted alongside it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        sums.check_outcome(result_ch.found, result_ch.out_of_range);
      if (item_ch.valid && item_ch.ready)
        sums.note_amount(item_ch.amount, item_ch.last);
      if (cfg_ch.valid && cfg_ch.ready)
        sums.set_register(cfg_ch.index, cfg_ch.data);
    end
  end

  // Watchdog: count edges with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles at %0t", IDLE_LIMIT, $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result sink: random stalls, none while a quiet phase runs.
  initial begin : result_sink
    int stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !quiet_phase) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else begin
        result_ch.ready = 1'b1;
        stall_left      = 0;
        if ($urandom_range(0, 2) == 0)
          stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          phase;
    int          n_sets;
    int          set_len;
    int          r;
    logic [11:0] tgt;
    logic [11:0] tl;

    rst            = 1'b1;
    item_ch.valid  = 1'b0;
    item_ch.amount = '0;
    item_ch.last   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = ssw_pkg::CFG_TARGET_SUM;
    cfg_ch.data    = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // --- Directed part -------------------------------------------------------
    // Registers at reset: the cap is zero, so nothing can be added.
    send_amount(24'd0, 1'b1);
    send_amount(24'd5, 1'b1);

    // Exact target, no tolerance.
    set_window(12'd100, 12'd0);
    send_amount(24'd40, 1'b0);
    send_amount(24'd0, 1'b0);            // zero amount: ignored
    send_amount(24'd60, 1'b1);           // 40 + 60 hits
    send_amount(24'd101, 1'b1);          // above the cap: set unchanged
    send_amount(24'd100, 1'b1);
    send_amount(24'hFF_FFFF, 1'b1);      // widest amount
    send_amount(24'd50, 1'b0);
    send_amount(24'd50, 1'b1);           // same amount twice reaches 100

    // Window reaches below zero and above the tracked range.
    set_window(12'd10, 12'hFFF);
    send_amount(24'd1, 1'b1);
    send_amount(24'd4095, 1'b1);
    send_amount(24'd4096, 1'b1);

    // Top of the tracked range with no slack.
    set_window(12'hFFF, 12'd0);
    send_amount(24'd4094, 1'b1);
    send_amount(24'd2048, 1'b0);
    send_amount(24'd2047, 1'b1);

    // Leave a set open under a wide cap, then narrow the registers: the sum
    // kept earlier stays and lands in the new window.
    set_window(12'd1000, 12'd0);
    send_amount(24'd150, 1'b0);
    set_window(12'd100, 12'd60);
    send_amount(24'd0, 1'b1);

    // Both registers at their extremes.
    set_window(12'hFFF, 12'hFFF);
    send_amount(24'd4095, 1'b1);

    // --- Random part ---------------------------------------------------------
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 9);
      if (r < 2)
        tgt = (r == 0) ? 12'd0 : 12'hFFF;
      else if (r < 6)
        tgt = 12'($urandom_range(1, 300));
      else
        tgt = 12'($urandom_range(0, 4095));
      r = $urandom_range(0, 9);
      if (r < 3)
        tl = 12'd0;
      else if (r < 4)
        tl = 12'hFFF;
      else if (r < 7)
        tl = 12'($urandom_range(1, 50));
      else
        tl = 12'($urandom_range(0, 4095));
      set_window(tgt, tl);

      quiet_phase = ($urandom_range(0, 4) == 0);
      n_sets      = $urandom_range(2, 8);
      for (int s = 0; s < n_sets; s++) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                              : $urandom_range(1, 10);
        for (int k = 0; k < set_len; k++)
          send_amount(pick_amount(), k == set_len - 1);
        // Pause the sender until the block has caught up, at least once.
        if (s == n_sets / 2 && (phase == 2 || $urandom_range(0, 5) == 0))
          drain_outcomes();
      end

      // Now and then carry an open set across the next register change.
      if ($urandom_range(0, 4) == 0) begin
        set_len = $urandom_range(1, 3);
        for (int k = 0; k < set_len; k++)
          send_amount(pick_amount(), 1'b0);
      end
      quiet_phase = 1'b0;
      phase++;
    end

    // --- Wind down -----------------------------------------------------------
    go_quiet();
    if (sums.errors == 0 && sums.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
